FILE: src/mslc_pkg.sv
// Shared types, constants, microcode program and sine function of the LFO cutoff block.
// Used by every module of the block; depends on nothing else.
package mslc_pkg;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LATCH,
		OP_PHASE,
		OP_DRAW_HELD,
		OP_DRAW_TARGET,
		OP_WALK_MUL,
		OP_WALK_ADD,
		OP_WAVE_MUL,
		OP_SUM,
		OP_DIV_MUL,
		OP_LOAD_OUT
	} mslc_op_t;

	typedef enum logic [2:0] {
		COND_NONE,
		COND_NO_REQ,
		COND_NO_ADV,
		COND_NO_CARRY,
		COND_OUT_BUSY
	} mslc_cond_t;

	typedef enum logic [1:0] {
		SHAPE_SINE,
		SHAPE_SQUARE,
		SHAPE_HOLD,
		SHAPE_WALK
	} mslc_shape_t;

	typedef logic [3:0] mslc_step_t;

	localparam mslc_step_t STEP_IDLE     = 4'd0;
	localparam mslc_step_t STEP_CHECK    = 4'd1;
	localparam mslc_step_t STEP_PHASE    = 4'd2;
	localparam mslc_step_t STEP_DRAW1    = 4'd3;
	localparam mslc_step_t STEP_DRAW2    = 4'd4;
	localparam mslc_step_t STEP_WALK_MUL = 4'd5;
	localparam mslc_step_t STEP_WALK_ADD = 4'd6;
	localparam mslc_step_t STEP_WAVE_MUL = 4'd7;
	localparam mslc_step_t STEP_SUM      = 4'd8;
	localparam mslc_step_t STEP_DIV_MUL  = 4'd9;
	localparam mslc_step_t STEP_DONE     = 4'd10;
	localparam mslc_step_t STEP_LAST     = STEP_DONE;

	typedef struct packed {
		mslc_op_t   op;
		mslc_cond_t cond;
		mslc_step_t target;
	} mslc_ctrl_t;

	typedef struct packed {
		logic req;
		logic adv;
		logic carry;
		logic out_busy;
	} mslc_status_t;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_SHAPE  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP  = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_BASE_CUTOFF = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SWEEP_DEPTH = 8'd3;

	localparam logic [15:0] PHASE_STEP_RESET  = 16'd546;
	localparam logic [11:0] BASE_CUTOFF_RESET = 12'd900;
	localparam logic [11:0] SWEEP_DEPTH_RESET = 12'd750;
	localparam logic [31:0] SEED_RESET        = 32'h0000_0055;

	localparam logic [31:0] LCG_MUL = 32'd1103515245;
	localparam logic [31:0] LCG_INC = 32'd12345;

	// The fraction is s / 1000 with s = cutoff * 32768; it saturates at and above this value.
	localparam logic signed [28:0] FRAC_LIMIT = 29'sd65536000;
	localparam logic [26:0]        DIV_RECIP  = 27'd68719477;
	localparam int                 DIV_SHIFT  = 36;

	function automatic mslc_ctrl_t ucode(input mslc_step_t step);
		mslc_ctrl_t w;
		w = '{op: OP_NOP, cond: COND_NONE, target: STEP_IDLE};
		case (step)
			STEP_IDLE:     w = '{op: OP_LATCH,       cond: COND_NO_REQ,   target: STEP_IDLE};
			STEP_CHECK:    w = '{op: OP_NOP,         cond: COND_NO_ADV,   target: STEP_WAVE_MUL};
			STEP_PHASE:    w = '{op: OP_PHASE,       cond: COND_NO_CARRY, target: STEP_WALK_MUL};
			STEP_DRAW1:    w = '{op: OP_DRAW_HELD,   cond: COND_NONE,     target: STEP_IDLE};
			STEP_DRAW2:    w = '{op: OP_DRAW_TARGET, cond: COND_NONE,     target: STEP_IDLE};
			STEP_WALK_MUL: w = '{op: OP_WALK_MUL,    cond: COND_NONE,     target: STEP_IDLE};
			STEP_WALK_ADD: w = '{op: OP_WALK_ADD,    cond: COND_NONE,     target: STEP_IDLE};
			STEP_WAVE_MUL: w = '{op: OP_WAVE_MUL,    cond: COND_NONE,     target: STEP_IDLE};
			STEP_SUM:      w = '{op: OP_SUM,         cond: COND_NONE,     target: STEP_IDLE};
			STEP_DIV_MUL:  w = '{op: OP_DIV_MUL,     cond: COND_NONE,     target: STEP_IDLE};
			STEP_DONE:     w = '{op: OP_LOAD_OUT,    cond: COND_OUT_BUSY, target: STEP_DONE};
			default:       w = '{op: OP_NOP,         cond: COND_NONE,     target: STEP_IDLE};
		endcase
		return w;
	endfunction

	// Quarter-wave fifth-order polynomial, coefficients in Q14, result in Q1.15.
	function automatic logic signed [15:0] sine_sample(input logic [15:0] ang);
		logic [1:0]  quad;
		logic [31:0] z;
		logic [31:0] z2;
		logic [31:0] p;
		quad = ang[15:14];
		z = {18'd0, ang[13:0]};
		if (quad[0]) begin
			z = 32'd16384 - z;
		end
		z2 = (z * z) >> 14;
		p = 32'd10512 - ((32'd1160 * z2) >> 14);
		p = 32'd25736 - ((p * z2) >> 14);
		p = ((p * z) >> 14) * 32'd2;
		if (p > 32'd32767) begin
			p = 32'd32767;
		end
		return quad[1] ? 16'(32'd0 - p) : 16'(p);
	endfunction

endpackage

FILE: src/mslc_sine_rom.sv
// Read-only sine table with a registered read port, indexed by the oscillator phase.
// Depends on mslc_pkg for the sample function that fills the table at elaboration.
module mslc_sine_rom #(
	parameter int ENTRIES = 256
) (
	input  logic               clk,
	input  logic [15:0]        phase,
	output logic signed [15:0] sample
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int PW    = 16 + $clog2(ENTRIES + 1);

	logic signed [15:0] rom [ENTRIES];
	logic [PW-1:0]      scaled;
	logic [IDX_W-1:0]   idx;
	logic signed [15:0] sample_q;

	for (genvar k = 0; k < ENTRIES; k++) begin : g_rom
		localparam logic [15:0] ANG = 16'((k * 65536) / ENTRIES);
		assign rom[k] = mslc_pkg::sine_sample(ANG);
	end

	assign scaled = PW'(phase) * PW'(ENTRIES);
	assign idx    = scaled[16 +: IDX_W];

	always_ff @(posedge clk) begin
		sample_q <= rom[idx];
	end

	assign sample = sample_q;

endmodule

FILE: src/mslc_sequencer.sv
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on mslc_pkg for the program, control word and status types.
module mslc_sequencer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mslc_pkg::mslc_status_t status,
	output mslc_pkg::mslc_ctrl_t   ctrl
);

	mslc_pkg::mslc_step_t step_q;
	mslc_pkg::mslc_step_t step_next;
	logic                 take_jump;

	assign ctrl = mslc_pkg::ucode(step_q);

	always_comb begin
		case (ctrl.cond)
			mslc_pkg::COND_NONE:     take_jump = 1'b0;
			mslc_pkg::COND_NO_REQ:   take_jump = !status.req;
			mslc_pkg::COND_NO_ADV:   take_jump = !status.adv;
			mslc_pkg::COND_NO_CARRY: take_jump = !status.carry;
			mslc_pkg::COND_OUT_BUSY: take_jump = status.out_busy;
			default:                 take_jump = 1'b0;
		endcase
		if (take_jump) begin
			step_next = ctrl.target;
		end else if (step_q == mslc_pkg::STEP_LAST) begin
			step_next = mslc_pkg::STEP_IDLE;
		end else begin
			step_next = step_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= mslc_pkg::STEP_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

FILE: src/mslc_datapath.sv
// Datapath: configuration and oscillator state, random generator, shared multiplier,
// wave selection and the result register. Depends on mslc_pkg and mslc_sine_rom.
module mslc_datapath #(
	parameter int SINE_ENTRIES = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mslc_pkg::mslc_ctrl_t                 ctrl,
	input  logic                                 in_valid,
	input  logic                                 advance,
	input  logic                                 cfg_we,
	input  logic [mslc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [mslc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 out_stall,
	output mslc_pkg::mslc_status_t               status,
	output logic                                 out_valid,
	output logic signed [15:0]                   wave_value,
	output logic signed [13:0]                   cutoff_freq,
	output logic [15:0]                          cutoff_fraction
);

	mslc_pkg::mslc_shape_t wave_shape_q;
	logic [15:0]           phase_step_q;
	logic [11:0]           base_cutoff_q;
	logic [11:0]           sweep_depth_q;

	logic [15:0]        phase_q;
	logic signed [15:0] held_q;
	logic signed [23:0] walk_q;
	logic signed [15:0] target_q;
	logic [31:0]        seed_q;
	logic               adv_q;
	logic               out_valid_q;

	logic signed [55:0] prod_q;
	logic signed [28:0] s_q;
	logic signed [15:0] wave_q;
	logic signed [15:0] wave_out_q;
	logic signed [13:0] hz_out_q;
	logic [15:0]        frac_out_q;

	logic [16:0]        phase_sum;
	logic [31:0]        seed_next;
	logic signed [15:0] draw;
	logic [16:0]        gain;
	logic signed [25:0] diff;
	logic signed [15:0] sine;
	logic signed [15:0] wave;
	logic signed [27:0] mul_a;
	logic signed [27:0] mul_b;
	logic signed [55:0] mul_p;
	logic signed [28:0] s_adj;
	logic [15:0]        frac;
	logic               out_free;

	mslc_sine_rom #(
		.ENTRIES(SINE_ENTRIES)
	) u_sine_rom (
		.clk    (clk),
		.phase  (phase_q),
		.sample (sine)
	);

	assign phase_sum = {1'b0, phase_q} + {1'b0, phase_step_q};
	assign seed_next = seed_q * mslc_pkg::LCG_MUL + mslc_pkg::LCG_INC;
	assign draw      = {~seed_next[31], seed_next[30:16]};
	assign gain      = (phase_step_q[15:14] != 2'b00) ? 17'h10000 : {phase_step_q[14:0], 2'b00};
	assign diff      = {{2{target_q[15]}}, target_q, 8'd0} - {{2{walk_q[23]}}, walk_q};
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		case (wave_shape_q)
			mslc_pkg::SHAPE_SINE:   wave = sine;
			mslc_pkg::SHAPE_SQUARE: wave = phase_q[15] ? 16'sh8000 : 16'sh7FFF;
			mslc_pkg::SHAPE_HOLD:   wave = held_q;
			mslc_pkg::SHAPE_WALK:   wave = walk_q[23:8];
			default:                wave = sine;
		endcase
	end

	always_comb begin
		case (ctrl.op)
			mslc_pkg::OP_WALK_MUL: begin
				mul_a = {{2{diff[25]}}, diff};
				mul_b = {11'd0, gain};
			end
			mslc_pkg::OP_WAVE_MUL: begin
				mul_a = {{12{wave[15]}}, wave};
				mul_b = {16'd0, sweep_depth_q};
			end
			mslc_pkg::OP_DIV_MUL: begin
				mul_a = {2'b00, s_q[25:0]};
				mul_b = {1'b0, mslc_pkg::DIV_RECIP};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign s_adj = s_q + (s_q[28] ? 29'sd32767 : 29'sd0);

	always_comb begin
		if (s_q[28] || (s_q == 29'sd0)) begin
			frac = 16'd0;
		end else if (s_q >= mslc_pkg::FRAC_LIMIT) begin
			frac = 16'hFFFF;
		end else begin
			frac = prod_q[mslc_pkg::DIV_SHIFT +: 16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_shape_q  <= mslc_pkg::SHAPE_SINE;
			phase_step_q  <= mslc_pkg::PHASE_STEP_RESET;
			base_cutoff_q <= mslc_pkg::BASE_CUTOFF_RESET;
			sweep_depth_q <= mslc_pkg::SWEEP_DEPTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mslc_pkg::CFG_WAVE_SHAPE:  wave_shape_q  <= mslc_pkg::mslc_shape_t'(cfg_data[1:0]);
				mslc_pkg::CFG_PHASE_STEP:  phase_step_q  <= cfg_data;
				mslc_pkg::CFG_BASE_CUTOFF: base_cutoff_q <= cfg_data[11:0];
				mslc_pkg::CFG_SWEEP_DEPTH: sweep_depth_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			held_q      <= '0;
			walk_q      <= '0;
			target_q    <= '0;
			seed_q      <= mslc_pkg::SEED_RESET;
			adv_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				mslc_pkg::OP_LATCH: begin
					if (in_valid) begin
						adv_q <= advance;
					end
				end
				mslc_pkg::OP_PHASE:       phase_q <= phase_sum[15:0];
				mslc_pkg::OP_DRAW_HELD: begin
					seed_q <= seed_next;
					held_q <= draw;
				end
				mslc_pkg::OP_DRAW_TARGET: begin
					seed_q   <= seed_next;
					target_q <= draw;
				end
				mslc_pkg::OP_WALK_ADD:    walk_q <= walk_q + prod_q[39:16];
				default: ;
			endcase
			if (ctrl.op == mslc_pkg::OP_LOAD_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			mslc_pkg::OP_WALK_MUL: prod_q <= mul_p;
			mslc_pkg::OP_WAVE_MUL: begin
				prod_q <= mul_p;
				wave_q <= wave;
			end
			mslc_pkg::OP_SUM:      s_q <= $signed({2'b00, base_cutoff_q, 15'd0}) + prod_q[28:0];
			mslc_pkg::OP_DIV_MUL:  prod_q <= mul_p;
			mslc_pkg::OP_LOAD_OUT: begin
				if (out_free) begin
					wave_out_q <= wave_q;
					hz_out_q   <= s_adj[28:15];
					frac_out_q <= frac;
				end
			end
			default: ;
		endcase
	end

	assign status = '{req: in_valid, adv: adv_q, carry: phase_sum[16], out_busy: !out_free};

	assign out_valid       = out_valid_q;
	assign wave_value      = wave_out_q;
	assign cutoff_freq     = hz_out_q;
	assign cutoff_fraction = frac_out_q;

endmodule

FILE: src/multi_shape_lfo_cutoff.sv
// Top level of the multi-shape LFO cutoff modulator: ports, sequencer and datapath.
// Depends on mslc_pkg, mslc_sequencer, mslc_datapath and mslc_sine_rom.

// One request with advance high moves the oscillator by one tick and then reports the wave
// (sine, square, sample and hold or smoothed random, Q1.15), the cutoff in hertz and the
// cutoff over 2000 Hz in Q0.16; with advance low it only reports. A microcode program runs
// one step per clock and all products go through a single shared multiplier. A request
// that only reports runs the latch, check, wave, sum, divide and load steps; one that
// advances adds the phase and walk steps, and a phase wrap adds two random draws. A result
// waiting in the output register holds the program in its last step until it is taken.
// Configuration writes are always ready and must be made while no request is in flight.
module multi_shape_lfo_cutoff #(
	parameter int SINE_ENTRIES = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              advance,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [15:0]                wave_value,
	output logic signed [13:0]                cutoff_freq,
	output logic [15:0]                       cutoff_fraction,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mslc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [mslc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	mslc_pkg::mslc_ctrl_t   ctrl;
	mslc_pkg::mslc_status_t status;

	assign cfg_ready = 1'b1;
	assign in_stall  = (ctrl.op != mslc_pkg::OP_LATCH);

	mslc_sequencer u_sequencer (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	mslc_datapath #(
		.SINE_ENTRIES(SINE_ENTRIES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.in_valid        (in_valid),
		.advance         (advance),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_stall       (out_stall),
		.status          (status),
		.out_valid       (out_valid),
		.wave_value      (wave_value),
		.cutoff_freq     (cutoff_freq),
		.cutoff_fraction (cutoff_fraction)
	);

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("Block accepted a second request without running its program.");

	a_result_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctrl.op == mslc_pkg::OP_LOAD_OUT))
		else $error("Result appeared outside the load step.");

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == mslc_pkg::OP_LOAD_OUT && out_valid && out_stall)
			|=> (ctrl.op == mslc_pkg::OP_LOAD_OUT))
		else $error("Program left the load step while the result register was full.");

endmodule
